// ===== rtl/core/prii_pkg.sv =====
// Package for the piecewise rate interval integrator: widths, reset values,
// register index codes and the structs passed between the pipeline modules.
// No dependencies.
`default_nettype none

package prii_pkg;

   localparam int MAX_INTERVALS = 4;
   localparam int INTERVALS_DEF = 4;

   localparam int TIME_W = 32;                 // Q16.16 time
   localparam int END_W  = TIME_W + 1;         // span end never wraps
   localparam int RATE_W = 24;                 // Q8.16 rate
   localparam int PROD_W = TIME_W + RATE_W;    // overlap times rate
   localparam int HALF_W = PROD_W + 1;         // sum of two products
   localparam int FRAC_W = 16;
   localparam int TAIL_W = END_W + FRAC_W;     // tail at rate one, Q.32
   localparam int ACC_W  = HALF_W + 2;         // two halves plus tail
   localparam int RES_W  = ACC_W - FRAC_W;
   localparam int OUT_W  = 48;

   localparam int DATA_W = 32;
   localparam int ADDR_W = 5;
   localparam int IDX_W  = 3;

   localparam logic [TIME_W-1:0] CUTOFF_RESET = '1;
   localparam logic [RATE_W-1:0] RATE_RESET   = RATE_W'(32'h0001_0000);

   typedef enum logic [IDX_W-1:0] {
      REG_CUTOFF_A = 3'd0,
      REG_CUTOFF_B = 3'd1,
      REG_CUTOFF_C = 3'd2,
      REG_CUTOFF_D = 3'd3,
      REG_RATE_A   = 3'd4,
      REG_RATE_B   = 3'd5,
      REG_RATE_C   = 3'd6,
      REG_RATE_D   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [MAX_INTERVALS-1:0][TIME_W-1:0] cutoff;
      logic [MAX_INTERVALS-1:0][RATE_W-1:0] rate;
   } cfg_type;

   // word leaving the multiply stage
   typedef struct packed {
      logic [MAX_INTERVALS-1:0][PROD_W-1:0] prod;
      logic [END_W-1:0]                     tail;
      logic                                 bypass;
      logic [TIME_W-1:0]                    length;
   } front_type;

endpackage

`default_nettype wire

// ===== rtl/core/piecewise_rate_interval_integrator.sv =====
// Piecewise rate interval integrator, top level.
// Four register stages lie between an accepted req word and rsp_valid: overlap, multiply,
// pair sum, total; the first loads on the edge that accepts the word.
// Throughput one word per cycle: every stage takes a new word each cycle when not blocked.
// Each stage stalls only while full and blocked, so bubbles close up under back-pressure.
// Reset clears all stage valid bits; cut-offs reset to all ones and rates to 1.0.
`default_nettype none

module piecewise_rate_interval_integrator import prii_pkg::*; #(
   parameter int INTERVALS = INTERVALS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [TIME_W-1:0] req_span_start,
   input  logic [TIME_W-1:0] req_span_length,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [OUT_W-1:0]  rsp_weighted_length,
   output logic              rsp_saturated,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type   cfg;
   logic      fr_valid, sum_ready;
   front_type fr_data;

   assign pready = 1'b1;

   prii_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   prii_front #(
      .INTERVALS (INTERVALS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_start  (req_span_start),
      .in_length (req_span_length),
      .out_valid (fr_valid),
      .out_ready (sum_ready),
      .out_data  (fr_data)
   );

   prii_sum u_sum (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (fr_valid),
      .in_ready     (sum_ready),
      .in_data      (fr_data),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_weighted (rsp_weighted_length)
   );

   // weighted sum is bounded well under 2^64, clipping never occurs
   assign rsp_saturated = 1'b0;

   a_ready_when_empty_out : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output stage");

   a_front_holds : assert property (@(posedge clock) disable iff (reset)
      fr_valid && !sum_ready |=> fr_valid)
      else $error("stalled front word lost");

   a_latency : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("word did not reach output after four free cycles");

endmodule

`default_nettype wire

// ===== rtl/core/prii_csr.sv =====
// Configuration registers: four cut-offs and four rates behind an APB-style port.
// Depends on prii_pkg.
`default_nettype none

module prii_csr import prii_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output cfg_type           cfg
);

   logic [MAX_INTERVALS-1:0][TIME_W-1:0] cutoff_ff, cutoff_in;
   logic [MAX_INTERVALS-1:0][RATE_W-1:0] rate_ff, rate_in;
   reg_index_type                        idx;
   logic                                 wr_en;

   assign idx   = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en = psel && penable && pwrite;

   always_comb begin
      cutoff_in = cutoff_ff;
      rate_in   = rate_ff;
      if (wr_en) begin
         case (idx)
            REG_CUTOFF_A: cutoff_in[0] = pwdata;
            REG_CUTOFF_B: cutoff_in[1] = pwdata;
            REG_CUTOFF_C: cutoff_in[2] = pwdata;
            REG_CUTOFF_D: cutoff_in[3] = pwdata;
            REG_RATE_A:   rate_in[0]   = pwdata[RATE_W-1:0];
            REG_RATE_B:   rate_in[1]   = pwdata[RATE_W-1:0];
            REG_RATE_C:   rate_in[2]   = pwdata[RATE_W-1:0];
            REG_RATE_D:   rate_in[3]   = pwdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= {MAX_INTERVALS{CUTOFF_RESET}};
         rate_ff   <= {MAX_INTERVALS{RATE_RESET}};
      end else begin
         cutoff_ff <= cutoff_in;
         rate_ff   <= rate_in;
      end
   end

   always_comb begin
      case (idx)
         REG_CUTOFF_A: prdata = cutoff_ff[0];
         REG_CUTOFF_B: prdata = cutoff_ff[1];
         REG_CUTOFF_C: prdata = cutoff_ff[2];
         REG_CUTOFF_D: prdata = cutoff_ff[3];
         REG_RATE_A:   prdata = DATA_W'(rate_ff[0]);
         REG_RATE_B:   prdata = DATA_W'(rate_ff[1]);
         REG_RATE_C:   prdata = DATA_W'(rate_ff[2]);
         REG_RATE_D:   prdata = DATA_W'(rate_ff[3]);
         default:      prdata = '0;
      endcase
   end

   assign cfg.cutoff = cutoff_ff;
   assign cfg.rate   = rate_ff;

endmodule

`default_nettype wire

// ===== rtl/core/prii_front.sv =====
// Front half of the pipeline: interval overlaps and tail (stage 1), then one
// overlap-by-rate multiply per interval (stage 2). Depends on prii_pkg.
`default_nettype none

module prii_front import prii_pkg::*; #(
   parameter int INTERVALS = INTERVALS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [TIME_W-1:0] in_start,
   input  logic [TIME_W-1:0] in_length,
   output logic              out_valid,
   input  logic              out_ready,
   output front_type         out_data
);

   logic                                 s1_valid_ff, s1_valid_in;
   logic [MAX_INTERVALS-1:0][TIME_W-1:0] s1_ovl_ff, s1_ovl_in;
   logic [END_W-1:0]                     s1_tail_ff, s1_tail_in;
   logic                                 s1_bypass_ff, s1_bypass_in;
   logic [TIME_W-1:0]                    s1_len_ff;

   logic      s2_valid_ff, s2_valid_in;
   front_type s2_data_ff, s2_data_in;

   logic              en1, en2;
   logic [END_W-1:0]  span_end;
   logic [TIME_W-1:0] last_cut;

   assign en2      = !s2_valid_ff || out_ready;
   assign en1      = !s1_valid_ff || en2;
   assign in_ready = en1;

   assign span_end = {1'b0, in_start} + {1'b0, in_length};
   assign last_cut = cfg.cutoff[INTERVALS-1];

   // overlap of the span with [lo, hi); empty when lo is above hi
   for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_lane
      logic [TIME_W-1:0] lo, lo_clip;
      logic [END_W-1:0]  hi_clip;
      if (k == 0) begin : g_first
         assign lo = '0;
      end else begin : g_rest
         assign lo = cfg.cutoff[k-1];
      end
      assign lo_clip = (in_start > lo) ? in_start : lo;
      assign hi_clip = (span_end < {1'b0, cfg.cutoff[k]}) ? span_end
                                                          : {1'b0, cfg.cutoff[k]};
      if (k < INTERVALS) begin : g_used
         assign s1_ovl_in[k] = (hi_clip > {1'b0, lo_clip})
                               ? TIME_W'(hi_clip - {1'b0, lo_clip}) : '0;
      end else begin : g_unused
         assign s1_ovl_in[k] = '0;
      end
   end

   assign s1_bypass_in = (in_start >= last_cut);
   assign s1_tail_in   = (span_end > {1'b0, last_cut}) ? span_end - {1'b0, last_cut}
                                                       : '0;
   assign s1_valid_in  = en1 ? in_valid : s1_valid_ff;

   always_comb begin
      for (int k = 0; k < MAX_INTERVALS; k++) begin
         s2_data_in.prod[k] = PROD_W'(s1_ovl_ff[k]) * PROD_W'(cfg.rate[k]);
      end
      s2_data_in.tail   = s1_tail_ff;
      s2_data_in.bypass = s1_bypass_ff;
      s2_data_in.length = s1_len_ff;
   end

   assign s2_valid_in = en2 ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ovl_ff    <= s1_ovl_in;
         s1_tail_ff   <= s1_tail_in;
         s1_bypass_ff <= s1_bypass_in;
         s1_len_ff    <= in_length;
      end
      if (en2) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/prii_sum.sv =====
// Back half of the pipeline: pairwise product sums (stage 3), then total with
// tail, truncation to Q32.16 and start-past-last-cut-off bypass (stage 4).
// Depends on prii_pkg.
`default_nettype none

module prii_sum import prii_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  front_type        in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [OUT_W-1:0] out_weighted
);

   logic              s3_valid_ff, s3_valid_in;
   logic [HALF_W-1:0] s3_half0_ff, s3_half0_in;
   logic [HALF_W-1:0] s3_half1_ff, s3_half1_in;
   logic [END_W-1:0]  s3_tail_ff;
   logic              s3_bypass_ff;
   logic [TIME_W-1:0] s3_len_ff;

   logic              s4_valid_ff, s4_valid_in;
   logic [OUT_W-1:0]  s4_res_ff, s4_res_in;

   logic              en3, en4;
   logic [ACC_W-1:0]  total;

   assign en4      = !s4_valid_ff || out_ready;
   assign en3      = !s3_valid_ff || en4;
   assign in_ready = en3;

   assign s3_half0_in = HALF_W'(in_data.prod[0]) + HALF_W'(in_data.prod[1]);
   assign s3_half1_in = HALF_W'(in_data.prod[2]) + HALF_W'(in_data.prod[3]);
   assign s3_valid_in = en3 ? in_valid : s3_valid_ff;

   // tail counts at rate one: shift into the Q.32 product scale
   assign total = ACC_W'(s3_half0_ff) + ACC_W'(s3_half1_ff)
                + ACC_W'({s3_tail_ff, {FRAC_W{1'b0}}});

   // total stays below 2^59, so the Q32.16 result never reaches the 48-bit ceiling
   assign s4_res_in   = s3_bypass_ff ? OUT_W'(s3_len_ff)
                                     : OUT_W'(total[ACC_W-1:FRAC_W]);
   assign s4_valid_in = en4 ? s3_valid_ff : s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_half0_ff  <= s3_half0_in;
         s3_half1_ff  <= s3_half1_in;
         s3_tail_ff   <= in_data.tail;
         s3_bypass_ff <= in_data.bypass;
         s3_len_ff    <= in_data.length;
      end
      if (en4) begin
         s4_res_ff <= s4_res_in;
      end
   end

   assign out_valid    = s4_valid_ff;
   assign out_weighted = s4_res_ff;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for piecewise_rate_interval_integrator: APB register set-up,
// directed interval edge spans, then randomised settings and spans with back-pressure.
// Depends on prii_pkg and the integrator RTL only.

module testbench import prii_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [OUT_W-1:0] weighted_length;
      logic             saturated;
   } weight_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [TIME_W-1:0] req_span_start;
   logic [TIME_W-1:0] req_span_length;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [OUT_W-1:0]  rsp_weighted_length;
   logic              rsp_saturated;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // register mirror used by the predictor
   logic [TIME_W-1:0] cutoff_mirror [MAX_INTERVALS];
   logic [RATE_W-1:0] rate_mirror [MAX_INTERVALS];

   weight_type expected_weights [$];
   int      errors = 0;
   int      spans_checked = 0;
   int      settings_used = 0;
   bit      tx_gaps = 1'b1;
   bit      rx_gaps = 1'b1;
   int      rx_hold_cycles = 0;

   piecewise_rate_interval_integrator uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_span_start      (req_span_start),
      .req_span_length     (req_span_length),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_weighted_length (rsp_weighted_length),
      .rsp_saturated       (rsp_saturated),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Weighted length of one span under the mirrored registers.
   function automatic weight_type weigh_span(input logic [TIME_W-1:0] start,
                                             input logic [TIME_W-1:0] length);
      logic [END_W-1:0] s, stop, lo, hi, a, b;
      logic [71:0]      acc;
      logic [71:0]      whole;
      weight_type       w;
      int               k;
      s = {1'b0, start};
      stop = s + length;
      lo = '0;
      acc = '0;
      for (k = 0; k < INTERVALS_DEF; k++) begin
         hi = {1'b0, cutoff_mirror[k]};
         a = (s > lo) ? s : lo;
         b = (stop < hi) ? stop : hi;
         if (b > a)
            acc += 72'(b - a) * 72'(rate_mirror[k]);
         lo = hi;
      end
      w.saturated = 1'b0;
      if (s >= lo) begin
         // start at or past the last cut-off: plain length
         w.weighted_length = OUT_W'(length);
      end else begin
         if (stop > lo)
            acc += 72'(stop - lo) << FRAC_W;
         whole = acc >> FRAC_W;
         if (whole > 72'({OUT_W{1'b1}})) begin
            w.weighted_length = '1;
            w.saturated = 1'b1;
         end else begin
            w.weighted_length = whole[OUT_W-1:0];
         end
      end
      return w;
   endfunction

   function automatic logic [31:0] low_mask(input int bits);
      return (bits >= 32) ? '1 : (32'(1) << bits) - 1;
   endfunction

   // Result checker: every accepted word against the oldest prediction.
   always @(posedge clock) begin
      weight_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_weights.size() == 0) begin
            $error("unexpected result word: weighted_length %h", rsp_weighted_length);
            errors++;
         end else begin
            want = expected_weights.pop_front();
            spans_checked++;
            if (rsp_weighted_length !== want.weighted_length) begin
               $error("weighted_length: expected %h, got %h",
                      want.weighted_length, rsp_weighted_length);
               errors++;
            end
            if (rsp_saturated !== want.saturated) begin
               $error("saturated: expected %b, got %b", want.saturated, rsp_saturated);
               errors++;
            end
         end
      end
   end

   // Output side: random stalls, or a counted hold-off when one is requested.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rx_hold_cycles--;
         end else begin
            rsp_ready <= !rx_gaps || ($urandom_range(99) >= 29);
         end
      end
   end

   // All tasks below are entered and left on a falling edge.
   task automatic read_reg(input reg_index_type idx);
      logic [DATA_W-1:0] want;
      if (idx < REG_RATE_A)
         want = cutoff_mirror[idx - REG_CUTOFF_A];
      else
         want = DATA_W'(rate_mirror[idx - REG_RATE_A]);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= ADDR_W'({idx, 2'b00});
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      if (prdata !== want) begin
         $error("prdata of %s: expected %h, got %h", idx.name(), want, prdata);
         errors++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [DATA_W-1:0] value);
      if (idx < REG_RATE_A)
         cutoff_mirror[idx - REG_CUTOFF_A] = value;
      else
         rate_mirror[idx - REG_RATE_A] = value[RATE_W-1:0];
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'({idx, 2'b00});
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      read_reg(idx);
   endtask

   task automatic set_intervals(input logic [TIME_W-1:0] ca, cb, cc, cd,
                                input logic [RATE_W-1:0] ra, rb, rc, rd);
      write_reg(REG_CUTOFF_A, ca);
      write_reg(REG_CUTOFF_B, cb);
      write_reg(REG_CUTOFF_C, cc);
      write_reg(REG_CUTOFF_D, cd);
      write_reg(REG_RATE_A, DATA_W'(ra));
      write_reg(REG_RATE_B, DATA_W'(rb));
      write_reg(REG_RATE_C, DATA_W'(rc));
      write_reg(REG_RATE_D, DATA_W'(rd));
      settings_used++;
   endtask

   task automatic send_span(input logic [TIME_W-1:0] start, input logic [TIME_W-1:0] length);
      int gap;
      gap = 0;
      if (tx_gaps && $urandom_range(99) < 29)
         gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_span_start <= start;
      req_span_length <= length;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      expected_weights.insert(expected_weights.size(), weigh_span(start, length));
      @(negedge clock);
   endtask

   // Stop sending and let every outstanding word come back.
   task automatic drain_spans();
      req_valid <= 1'b0;
      while (expected_weights.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic random_setting();
      logic [TIME_W-1:0] c [MAX_INTERVALS];
      logic [TIME_W-1:0] t;
      logic [RATE_W-1:0] r [MAX_INTERVALS];
      int style, bits, i, k;
      style = $urandom_range(2);
      bits = 12 + 8 * $urandom_range(2, 0) + ($urandom_range(1) ? 8 : 0);
      for (k = 0; k < MAX_INTERVALS; k++)
         c[k] = $urandom & low_mask(bits);
      if (style != 1) begin
         for (i = 0; i < MAX_INTERVALS - 1; i++)
            for (k = 0; k < MAX_INTERVALS - 1; k++)
               if (c[k] > c[k+1]) begin
                  t = c[k];
                  c[k] = c[k+1];
                  c[k+1] = t;
               end
      end
      if (style == 2) begin
         // empty interval, and one end pinned to an extreme
         c[2] = c[1];
         if ($urandom_range(1))
            c[0] = '0;
         else
            c[3] = '1;
      end
      for (k = 0; k < MAX_INTERVALS; k++)
         case ($urandom_range(4))
            0:       r[k] = '0;
            1:       r[k] = '1;
            2:       r[k] = RATE_RESET;
            default: r[k] = RATE_W'($urandom);
         endcase
      set_intervals(c[0], c[1], c[2], c[3], r[0], r[1], r[2], r[3]);
   endtask

   // Mostly spans starting near a cut-off, some fully random words.
   task automatic random_spans(input int count);
      logic [TIME_W-1:0] s, l, off;
      int n;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(9) < 2) begin
            s = $urandom;
            l = $urandom;
         end else begin
            off = $urandom & low_mask($urandom_range(24));
            s = cutoff_mirror[$urandom_range(MAX_INTERVALS - 1)];
            s = $urandom_range(1) ? s - off : s + off;
            l = $urandom & low_mask($urandom_range(32));
         end
         send_span(s, l);
      end
   endtask

   task automatic test_reset_values();
      int k;
      for (k = 0; k < MAX_INTERVALS; k++) begin
         read_reg(reg_index_type'(REG_CUTOFF_A + k));
         read_reg(reg_index_type'(REG_RATE_A + k));
      end
      settings_used++;
      send_span('0, '1);
      send_span('1, '1);
      send_span(32'h1234_5678, '0);
      drain_spans();
   endtask

   task automatic test_interval_edges();
      set_intervals(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                    '0, '1, 24'h00_8000, RATE_RESET);
      send_span(32'h0000_0000, 32'h0005_0000);   // all intervals plus tail
      send_span(32'h0001_0000, 32'h0001_0000);   // exactly the second interval
      send_span(32'h0000_8000, 32'h0001_0000);   // straddles first and second
      send_span(32'h0004_0000, 32'h0000_1234);   // start on the last cut-off
      send_span(32'h0003_ffff, 32'h0000_0002);   // one below it, short tail
      send_span(32'h9000_0000, 32'hffff_ffff);   // well past the last cut-off
      send_span(32'h0002_8000, 32'h0000_0000);   // empty span
      send_span(32'h0000_0000, 32'hffff_ffff);
      send_span(32'hffff_ffff, 32'hffff_ffff);
      send_span(32'h0003_0000, 32'hffff_ffff);   // end needs the carry bit
      drain_spans();
   endtask

   task automatic test_unordered_cutoffs();
      set_intervals(32'h0008_0000, 32'h0002_0000, 32'h0006_0000, 32'h0004_0000,
                    24'h02_0000, 24'h00_4000, '1, RATE_RESET);
      send_span(32'h0000_0000, 32'h0010_0000);
      send_span(32'h0003_0000, 32'h0002_0000);
      send_span(32'h0004_0000, 32'h0001_0000);
      send_span(32'h0001_0000, 32'h0000_8000);
      drain_spans();
   endtask

   task automatic test_no_intervals();
      // every cut-off at zero: any start is past the last one
      set_intervals('0, '0, '0, '0, '1, '1, '1, '1);
      send_span(32'h0000_0000, 32'hffff_ffff);
      send_span(32'h0000_0000, 32'h0000_0000);
      send_span(32'h7fff_ffff, 32'h0000_0005);
      drain_spans();
   endtask

   task automatic test_backpressure();
      random_setting();
      tx_gaps = 1'b0;
      rx_hold_cycles = 100;
      random_spans(40);
      tx_gaps = 1'b1;
      drain_spans();
   endtask

   task automatic test_random_settings();
      int phase;
      for (phase = 0; phase < 8; phase++) begin
         random_setting();
         tx_gaps = (phase != 3);
         rx_gaps = (phase != 3);
         random_spans(164);
         drain_spans();
      end
      tx_gaps = 1'b1;
      rx_gaps = 1'b1;
   endtask

   initial begin
      int k;
      for (k = 0; k < MAX_INTERVALS; k++) begin
         cutoff_mirror[k] = CUTOFF_RESET;
         rate_mirror[k] = RATE_RESET;
      end
      reset = 1'b1;
      req_valid = 1'b0;
      req_span_start = '0;
      req_span_length = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_values();
      test_interval_edges();
      test_unordered_cutoffs();
      test_no_intervals();
      test_backpressure();
      test_random_settings();

      $display("%0d spans checked over %0d register settings: interval edges, unordered",
               spans_checked, settings_used);
      $display("and zero cut-offs, random spans near cut-offs, a long output stall");
      if (errors == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
